[hw/rtl/maps_pkg.sv]
// Shared constants for the moving-average percent scaler.
// Holds the field widths, the percent mapping constants and parameter defaults.
// No dependencies; every other file of the block but maps_cell imports it.
package maps_pkg;

    // Widths of the channel fields.
    localparam int SAMPLE_W  = 10;
    localparam int PERCENT_W = 7;

    // Defaults for the top-level parameters.
    localparam int SAMPLE_COUNT_DEF = 8;
    localparam int SAMPLE_BITS_DEF  = 10;

    // Percent mapping: (avg - MAP_LOW) * PCT_MAX / (MAP_HIGH - MAP_LOW), clamped.
    localparam int MAP_LOW  = 10;
    localparam int MAP_HIGH = 1013;
    localparam int PCT_MAX  = 100;
    localparam int MAP_SPAN = MAP_HIGH - MAP_LOW;

    // Width of the clamped offset and of the offset times PCT_MAX.
    localparam int SPAN_W  = $clog2(MAP_SPAN + 1);
    localparam int PCT_X_W = $clog2(MAP_SPAN * PCT_MAX + 1);

    // Division by MAP_SPAN as a multiply by a rounded-up reciprocal. With a
    // dividend below 2**PCT_X_W the rounding error stays below one step.
    localparam int PCT_SHIFT  = PCT_X_W + SPAN_W;
    localparam int PCT_RECIP_W = PCT_SHIFT - SPAN_W + 2;
    localparam logic [PCT_RECIP_W-1:0] PCT_RECIP =
        PCT_RECIP_W'(((64'd1 << PCT_SHIFT) + 64'(MAP_SPAN) - 64'd1) / 64'(MAP_SPAN));
    localparam int PCT_PROD_W = PCT_X_W + PCT_RECIP_W;

endpackage

[hw/rtl/maps_in_if.sv]
// Sample channel of the moving-average percent scaler.
// Carries one converter sample and its priming flag per item.
// Depends on maps_pkg for the field width.
interface maps_in_if;
    import maps_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                prime;

    modport source (output valid, output sample, output prime, input ready);
    modport sink   (input valid, input sample, input prime, output ready);

endinterface

[hw/rtl/maps_out_if.sv]
// Result channel of the moving-average percent scaler.
// Carries one percent value per item.
// Depends on maps_pkg for the field width.
interface maps_out_if;
    import maps_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PERCENT_W-1:0] percent;

    modport source (output valid, output percent, input ready);
    modport sink   (input valid, input percent, output ready);

endinterface

[hw/rtl/maps_cell.sv]
// One cell of the sample delay line.
// Holds one sample and passes it to the next cell whenever the line shifts.
// No package dependencies.
module maps_cell #(
    parameter int WIDTH = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] value_reg;
    logic [WIDTH-1:0] value_next;

    // Take the neighbor's sample on a shift, otherwise hold.
    always_comb
    begin
        value_next = value_reg;
        if (shift)
        begin
            value_next = d;
        end
    end

    // The delay line starts out as all zeros.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign q = value_reg;

endmodule

[hw/rtl/maps_scaler.sv]
// Four-stage pipeline from running total to clamped percent.
// Stages: total, average, scaled offset, percent (the output register).
// Depends on maps_pkg and maps_out_if.
module maps_scaler #(
    parameter int SAMPLE_COUNT = maps_pkg::SAMPLE_COUNT_DEF,
    parameter int SAMPLE_BITS  = maps_pkg::SAMPLE_BITS_DEF,
    parameter int TOTAL_W      = SAMPLE_BITS + $clog2(SAMPLE_COUNT)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load_valid,
    output logic               load_ready,
    input  logic [TOTAL_W-1:0] load_total,
    maps_out_if.source         out
);
    import maps_pkg::*;

    // Division by SAMPLE_COUNT as a multiply by a rounded-up reciprocal.
    localparam int AVG_SHIFT   = TOTAL_W + $clog2(SAMPLE_COUNT);
    localparam int AVG_RECIP_W = AVG_SHIFT + 1;
    localparam int AVG_PROD_W  = TOTAL_W + AVG_RECIP_W;
    localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
        AVG_RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));

    // Stage valids and data.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic [SAMPLE_BITS-1:0] avg_reg, avg_next;
    logic [PCT_X_W-1:0]     x_reg, x_next;
    logic [PERCENT_W-1:0]   pct_reg, pct_next;

    logic ready1, ready2, ready3, ready4;
    logic [AVG_PROD_W-1:0] avg_prod;
    logic [PCT_X_W-1:0]    avg_ext;
    logic [SPAN_W-1:0]     offset;
    logic [PCT_PROD_W-1:0] pct_prod;

    // A stage takes new data when it is empty or its content moves on.
    assign ready4 = !v4_reg || out.ready;
    assign ready3 = !v3_reg || ready4;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;
    assign load_ready = ready1;

    // Average: total times the reciprocal, upper bits.
    assign avg_prod = AVG_PROD_W'(total_reg) * AVG_PROD_W'(AVG_RECIP);

    // Clamp the average into the mapped span and scale the offset by PCT_MAX.
    assign avg_ext = PCT_X_W'(avg_reg);
    always_comb
    begin
        if (avg_ext <= PCT_X_W'(MAP_LOW))
        begin
            offset = '0;
        end
        else if (avg_ext >= PCT_X_W'(MAP_HIGH))
        begin
            offset = SPAN_W'(MAP_SPAN);
        end
        else
        begin
            offset = SPAN_W'(avg_ext - PCT_X_W'(MAP_LOW));
        end
    end

    // Percent: scaled offset divided by the span through its reciprocal.
    assign pct_prod = PCT_PROD_W'(x_reg) * PCT_PROD_W'(PCT_RECIP);

    // Next-state logic for all stages.
    always_comb
    begin
        v1_next    = v1_reg;
        v2_next    = v2_reg;
        v3_next    = v3_reg;
        v4_next    = v4_reg;
        total_next = total_reg;
        avg_next   = avg_reg;
        x_next     = x_reg;
        pct_next   = pct_reg;
        if (ready1)
        begin
            v1_next    = load_valid;
            total_next = load_total;
        end
        if (ready2)
        begin
            v2_next  = v1_reg;
            avg_next = avg_prod[AVG_SHIFT +: SAMPLE_BITS];
        end
        if (ready3)
        begin
            v3_next = v2_reg;
            x_next  = PCT_X_W'(PCT_X_W'(offset) * PCT_X_W'(PCT_MAX));
        end
        if (ready4)
        begin
            v4_next  = v3_reg;
            pct_next = pct_prod[PCT_SHIFT +: PERCENT_W];
        end
    end

    // Stage valids clear at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // Stage data needs no reset.
    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        avg_reg   <= avg_next;
        x_reg     <= x_next;
        pct_reg   <= pct_next;
    end

    assign out.valid   = v4_reg;
    assign out.percent = pct_reg;

    // The percent leaving the block never exceeds the top of the scale.
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> pct_reg <= PERCENT_W'(PCT_MAX))
        else $error("percent above full scale");

    // The scaled offset never exceeds the clamped span times PCT_MAX.
    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> x_reg <= PCT_X_W'(MAP_SPAN * PCT_MAX))
        else $error("scaled offset out of range");

    // While the output stalls, a waiting item in the stage before it is kept.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && v4_reg && !out.ready) |=> (v3_reg && $stable(x_reg)))
        else $error("stalled item lost behind the output register");

endmodule

[hw/rtl/moving_average_percent_scaler.sv]
// Top level of the moving-average percent scaler.
// A delay line of maps_cell instances holds the window; maps_scaler maps the total.
// Depends on maps_pkg, maps_in_if, maps_out_if, maps_cell and maps_scaler.
//
// Usage:
//   samples: one converter reading per item. With prime set the reading only
//            enters the window and no result follows; otherwise one result does.
//   results: the window average mapped to 0..100 percent, in input order.
//   Both channels move an item when valid and ready are high at a clock edge.
// Pipeline: a result passes through four registers (total, average, scaled
//   offset and output register), loaded in that order, the first by the edge
//   that takes the sample.
// Throughput: one item per cycle while results are taken. The window update
//   lands with each taken sample: the running total drops the sample leaving
//   the last cell and adds the new one, every cell passing its sample on.
// Reset: all cells and the running total clear to zero, the pipeline empties.
// Stall: while results are not taken the four stages keep filling; samples
//   stay accepted until every stage holds an item, then ready drops. Priming
//   items wait on the same ready.
module moving_average_percent_scaler #(
    parameter int SAMPLE_COUNT = maps_pkg::SAMPLE_COUNT_DEF,
    parameter int SAMPLE_BITS  = maps_pkg::SAMPLE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    maps_in_if.sink    samples,
    maps_out_if.source results
);
    import maps_pkg::*;

    localparam int TOTAL_W = SAMPLE_BITS + $clog2(SAMPLE_COUNT);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX =
        TOTAL_W'(SAMPLE_COUNT * ((1 << SAMPLE_BITS) - 1));

    logic                   accept;
    logic                   scl_ready;
    logic [SAMPLE_BITS-1:0] value;
    logic [SAMPLE_BITS-1:0] tap [SAMPLE_COUNT+1];
    logic [TOTAL_W-1:0]     total_reg;
    logic [TOTAL_W-1:0]     total_next;

    assign samples.ready = scl_ready;
    assign accept        = samples.valid && scl_ready;

    // Only the low SAMPLE_BITS of a reading count.
    assign value  = SAMPLE_BITS'(samples.sample);
    assign tap[0] = value;

    // Delay line: the last cell always holds the oldest sample of the window.
    for (genvar i = 0; i < SAMPLE_COUNT; i++)
    begin : g_cell
        maps_cell #(
            .WIDTH (SAMPLE_BITS)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (accept),
            .d     (tap[i]),
            .q     (tap[i+1])
        );
    end

    // Running total: the oldest sample leaves, the new one joins.
    always_comb
    begin
        total_next = total_reg;
        if (accept)
        begin
            total_next = total_reg + TOTAL_W'(value) - TOTAL_W'(tap[SAMPLE_COUNT]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else
        begin
            total_reg <= total_next;
        end
    end

    // Normal samples carry the new total into the scaling pipeline.
    maps_scaler #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .TOTAL_W      (TOTAL_W)
    ) u_scaler (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (samples.valid && !samples.prime),
        .load_ready (scl_ready),
        .load_total (total_next),
        .out        (results)
    );

    // The total never exceeds a full window of largest samples.
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TOTAL_MAX)
        else $error("running total exceeds a full window");

endmodule

[tb/maps_window_checker.sv]
// Checker for the moving-average percent scaler: watches both channels and predicts results.
// Keeps its own copy of the sample window and running sum and compares each percent in order.
// Depends on maps_pkg, maps_in_if and maps_out_if.
`timescale 1ns / 1ps

module maps_window_checker
    import maps_pkg::*;
#(
    parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    maps_in_if   samples,
    maps_out_if  results,
    output int   errors,
    output int   pending,
    output int   taken,
    output int   primed,
    output int   checked
);

    localparam int SUM_W = SAMPLE_W + $clog2(SAMPLE_COUNT + 1);

    logic [SAMPLE_W-1:0]  window [SAMPLE_COUNT];
    logic [SUM_W-1:0]     window_sum;
    int                   window_slot;
    logic [PERCENT_W-1:0] expected_percent [$];

    // Map a window sum to percent: truncated average, offset, scale, clamp.
    function automatic logic [PERCENT_W-1:0] percent_of_sum(input logic [SUM_W-1:0] sum);
        int avg;
        int scaled;
        avg = int'(sum) / SAMPLE_COUNT;
        // Signed division truncates toward zero, so averages just below the
        // low end land on zero before the clamp.
        scaled = (avg - MAP_LOW) * PCT_MAX / MAP_SPAN;
        if (scaled < 0)
        begin
            scaled = 0;
        end
        else if (scaled > PCT_MAX)
        begin
            scaled = PCT_MAX;
        end
        return PERCENT_W'(scaled);
    endfunction

    // Compare accepted results, then fold accepted samples into the window.
    always @(posedge clk or negedge rst_n)
    begin
        logic [SAMPLE_W-1:0]  value;
        logic [PERCENT_W-1:0] want;
        if (!rst_n)
        begin
            for (int i = 0; i < SAMPLE_COUNT; i++)
            begin
                window[i] = '0;
            end
            window_sum  = '0;
            window_slot = 0;
            expected_percent.delete();
            errors  = 0;
            taken   = 0;
            primed  = 0;
            checked = 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (expected_percent.size() == 0)
                begin
                    errors++;
                    $error("percent: result with no expectation waiting, expected none, actual %0d",
                           results.percent);
                end
                else
                begin
                    want = expected_percent.pop_front();
                    checked++;
                    if (results.percent !== want)
                    begin
                        errors++;
                        $error("percent mismatch: expected %0d, actual %0d",
                               want, results.percent);
                    end
                end
            end
            if (samples.valid && samples.ready)
            begin
                value = samples.sample & SAMPLE_W'((1 << SAMPLE_BITS) - 1);
                // The new sample replaces the oldest one in the sum and the ring.
                window_sum = window_sum - window[window_slot] + value;
                window[window_slot] = value;
                window_slot = (window_slot == SAMPLE_COUNT - 1) ? 0 : window_slot + 1;
                taken++;
                if (samples.prime)
                begin
                    primed++;
                end
                else
                begin
                    expected_percent.push_back(percent_of_sum(window_sum));
                end
            end
        end
        pending = expected_percent.size();
    end

endmodule

[tb/tb.sv]
// Top of the moving-average percent scaler testbench: clock, reset, stimulus and verdict.
// Drives samples with random gaps and result stalls; maps_window_checker does the checking.
// Depends on maps_pkg, maps_in_if, maps_out_if, maps_window_checker and the block itself.
`timescale 1ns / 1ps

module tb;
    import maps_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int LONG_HOLD    = 120;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic clk;
    logic rst_n;

    maps_in_if  sample_ch ();
    maps_out_if result_ch ();

    int errors;
    int pending;
    int taken;
    int primed;
    int checked;

    // Controls of the sample driver, the result receiver and the watchdog.
    bit sender_idle;
    bit sink_idle;
    bit hold_request;
    int quiet_cycles;

    // State of the current run of similar samples.
    int run_left;
    int run_level;

    moving_average_percent_scaler #(
        .SAMPLE_COUNT (SAMPLE_COUNT_DEF),
        .SAMPLE_BITS  (SAMPLE_BITS_DEF)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch)
    );

    maps_window_checker #(
        .SAMPLE_COUNT (SAMPLE_COUNT_DEF),
        .SAMPLE_BITS  (SAMPLE_BITS_DEF)
    ) i_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .errors  (errors),
        .pending (pending),
        .taken   (taken),
        .primed  (primed),
        .checked (checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Offer one item and hold it until it is accepted; sometimes idle afterwards.
    task automatic send_item(input logic [SAMPLE_W-1:0] s, input logic p);
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        sample_ch.prime  <= p;
        do
        begin
            @(posedge clk);
        end
        while (!sample_ch.ready);
        if (sender_idle && $urandom_range(0, 4) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // Pick the next item: mostly runs of similar readings so that the average
    // settles near the ends of the scale, with some noise mixed in.
    task automatic pick_item(output logic [SAMPLE_W-1:0] s, output logic p);
        int level;
        if (run_left == 0)
        begin
            run_left = $urandom_range(6, 20);
            case ($urandom_range(0, 5))
                0: run_level = $urandom_range(0, 20);
                1: run_level = $urandom_range(1000, 1023);
                2: run_level = (1 << SAMPLE_W) - 1;
                3: run_level = $urandom_range(MAP_LOW - 2, MAP_LOW + 2);
                4: run_level = $urandom_range(MAP_HIGH - 4, MAP_HIGH + 4);
                default: run_level = $urandom_range(0, (1 << SAMPLE_W) - 1);
            endcase
        end
        run_left--;
        if ($urandom_range(0, 9) == 0)
        begin
            s = SAMPLE_W'($urandom);
        end
        else
        begin
            level = run_level + $urandom_range(0, 16) - 8;
            if (level < 0)
            begin
                level = 0;
            end
            else if (level > (1 << SAMPLE_W) - 1)
            begin
                level = (1 << SAMPLE_W) - 1;
            end
            s = SAMPLE_W'(level);
        end
        p = ($urandom_range(0, 3) == 0);
    endtask

    // Result receiver: random stall bursts, plus one long hold on request.
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (!rst_n)
            begin
                result_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (sink_idle && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready)
            || (result_ch.valid && result_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        logic [SAMPLE_W-1:0] s;
        logic                p;
        sender_idle  = 1'b1;
        sink_idle    = 1'b1;
        hold_request = 1'b0;
        quiet_cycles = 0;
        run_left     = 0;
        run_level    = 0;
        rst_n = 1'b0;
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;
        sample_ch.prime  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty window, full window at the top, window at the low end.
        send_item(SAMPLE_W'(0), 1'b0);
        repeat (SAMPLE_COUNT_DEF) send_item(SAMPLE_W'((1 << SAMPLE_W) - 1), 1'b1);
        send_item(SAMPLE_W'((1 << SAMPLE_W) - 1), 1'b0);
        repeat (SAMPLE_COUNT_DEF - 1) send_item(SAMPLE_W'(MAP_LOW), 1'b1);
        send_item(SAMPLE_W'(MAP_LOW), 1'b0);
        send_item(SAMPLE_W'(MAP_HIGH), 1'b0);
        send_item(SAMPLE_W'(10'b10_0000_0000), 1'b0);
        send_item(SAMPLE_W'(10'b01_0101_0101), 1'b0);
        send_item(SAMPLE_W'(10'b10_1010_1010), 1'b0);

        // Random traffic with idling on both sides.
        repeat (330)
        begin
            pick_item(s, p);
            send_item(s, p);
        end

        // Long result hold while samples keep coming, so the block backs up.
        sender_idle  = 1'b0;
        hold_request = 1'b1;
        repeat (40)
        begin
            pick_item(s, p);
            send_item(s, p);
        end
        sender_idle = 1'b1;

        // Pause until every expected result has come out. Wait for the next edge first, so
        // that the checker has counted the last accepted sample.
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);

        repeat (300)
        begin
            pick_item(s, p);
            send_item(s, p);
        end

        // Last part at full rate on both sides.
        sender_idle = 1'b0;
        sink_idle   = 1'b0;
        repeat (160)
        begin
            pick_item(s, p);
            send_item(s, p);
        end
        sample_ch.valid <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d samples accepted (%0d priming), %0d percent results checked,",
                 taken, primed, checked);
        $display("Summary: with random gaps, a long result hold and a full drain mid-run.");
        if (errors == 0 && pending == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
